[src/mcfb_pkg.sv]
// Shared constants, types and codes for the motor command frame builder.
`timescale 1ns / 1ps

package mcfb_pkg;

    // Command codes on the input
    localparam logic [1:0] CMD_KEEP_ALIVE  = 2'd0;
    localparam logic [1:0] CMD_SET_CURRENT = 2'd1;
    localparam logic [1:0] CMD_SET_SPEED   = 2'd2;
    localparam logic [1:0] CMD_UNUSED      = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_CURRENT_GAIN = 2'd0;
    localparam logic [1:0] CFG_SPEED_GAIN   = 2'd1;

    // Gain reset values
    localparam logic [15:0] RESET_CURRENT_GAIN = 16'd1000;
    localparam logic [15:0] RESET_SPEED_GAIN   = 16'd250;

    // Frame bytes
    localparam logic [7:0] ID_KEEP_ALIVE  = 8'd30;
    localparam logic [7:0] ID_SET_CURRENT = 8'd6;
    localparam logic [7:0] ID_SET_SPEED   = 8'd8;
    localparam logic [7:0] FRAME_START    = 8'd2;
    localparam logic [7:0] FRAME_END      = 8'd3;
    localparam logic [7:0] PAY_LEN_SHORT  = 8'd1;
    localparam logic [7:0] PAY_LEN_LONG   = 8'd5;

    // CRC-16/XMODEM
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'h0000;

    // Byte positions within a frame
    localparam logic [3:0] POS_START      = 4'd0;
    localparam logic [3:0] POS_LEN        = 4'd1;
    localparam logic [3:0] POS_ID         = 4'd2;
    localparam logic [3:0] POS_SHORT_CRCH = 4'd3;
    localparam logic [3:0] POS_SHORT_CRCL = 4'd4;
    localparam logic [3:0] POS_SHORT_END  = 4'd5;
    localparam logic [3:0] POS_VAL_B3     = 4'd3;
    localparam logic [3:0] POS_VAL_B2     = 4'd4;
    localparam logic [3:0] POS_VAL_B1     = 4'd5;
    localparam logic [3:0] POS_VAL_B0     = 4'd6;
    localparam logic [3:0] POS_LONG_CRCH  = 4'd7;
    localparam logic [3:0] POS_LONG_CRCL  = 4'd8;
    localparam logic [3:0] POS_LONG_END   = 4'd9;

    // Default depth of the request queue
    localparam int QUEUE_DEPTH = 2;

    // One classified command waiting for the byte sequencer
    typedef struct packed {
        logic        long_frame;
        logic [7:0]  id;
        logic [31:0] scaled;
    } frame_req_t;

    // Queue head as seen by the sequencer
    typedef struct packed {
        logic       valid;
        frame_req_t req;
    } queue_head_t;

endpackage

[src/motor_command_frame_builder.sv]
// Top level of the motor command frame builder.
//
//  channel   dir  handshake                      content
//  s_axis    in   s_axis_tvalid/s_axis_tready    tuser: cmd[1:0]; tdata: value[24:0], zero[31:25]
//  m_axis    out  m_axis_tvalid/m_axis_tready    tdata: out_byte[7:0]; tlast: last
//  cfg       in   cfg_we (no wait)               cfg_index, cfg_wdata[15:0]
//
// One frame byte leaves per cycle while m_axis_tready is high: a keep-alive frame has 6 bytes, a set current or
// set speed frame 10, set by the byte sequencer in the back end.
// An accepted item waits in the request queue; its first byte leaves from the registered byte output.
// Reset sets current_gain to 1000, speed_gain to 250 and empties the request queue.
// A stalled byte output holds its byte; items are taken until the queue is full.
`timescale 1ns / 1ps

module motor_command_frame_builder
#(
    parameter int QUEUE_DEPTH = mcfb_pkg::QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // value[24:0], zero pad [31:25]
    input  logic [1:0]  s_axis_tuser,   // cmd[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // out_byte[7:0]
    output logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    logic                  queue_full;
    logic                  push;
    logic                  pop;
    mcfb_pkg::frame_req_t  push_req;
    mcfb_pkg::queue_head_t head;

    // Classify and scale incoming items
    mcfb_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .cmd        (s_axis_tuser),
        .value      (s_axis_tdata[24:0]),
        .queue_full (queue_full),
        .push       (push),
        .push_req   (push_req)
    );

    // Buffer requests between the two sides
    mcfb_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_req (push_req),
        .full     (queue_full),
        .pop      (pop),
        .head     (head)
    );

    // Emit frame bytes
    mcfb_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_byte  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

[src/mcfb_front.sv]
// Front end: gain registers, command classification and value scaling.
`timescale 1ns / 1ps

module mcfb_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_wdata,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          cmd,
    input  logic [24:0]         value,
    input  logic                queue_full,
    output logic                push,
    output mcfb_pkg::frame_req_t push_req
);

    logic [15:0]        current_gain_reg;
    logic [15:0]        current_gain_next;
    logic [15:0]        speed_gain_reg;
    logic [15:0]        speed_gain_next;
    logic [15:0]        gain;
    logic signed [24:0] value_s;
    logic signed [16:0] gain_s;
    logic signed [41:0] product;

    // Latch configuration writes
    always_comb
    begin
        current_gain_next = current_gain_reg;
        speed_gain_next   = speed_gain_reg;
        if (cfg_we)
        begin
            if (cfg_index == mcfb_pkg::CFG_CURRENT_GAIN)
            begin
                current_gain_next = cfg_wdata;
            end
            if (cfg_index == mcfb_pkg::CFG_SPEED_GAIN)
            begin
                speed_gain_next = cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_gain_reg <= mcfb_pkg::RESET_CURRENT_GAIN;
            speed_gain_reg   <= mcfb_pkg::RESET_SPEED_GAIN;
        end
        else
        begin
            current_gain_reg <= current_gain_next;
            speed_gain_reg   <= speed_gain_next;
        end
    end

    // Scale the signed value by the selected unsigned gain, wrap to 32 bits
    assign gain    = (cmd == mcfb_pkg::CMD_SET_CURRENT) ? current_gain_reg : speed_gain_reg;
    assign value_s = $signed(value);
    assign gain_s  = $signed({1'b0, gain});
    assign product = 42'(value_s) * 42'(gain_s);

    // Classify the command; drop the unused code
    assign in_ready = !queue_full;
    assign push     = in_valid && !queue_full && (cmd != mcfb_pkg::CMD_UNUSED);

    always_comb
    begin
        push_req.long_frame = (cmd != mcfb_pkg::CMD_KEEP_ALIVE);
        push_req.scaled     = product[31:0];
        unique case (cmd)
            mcfb_pkg::CMD_SET_CURRENT: push_req.id = mcfb_pkg::ID_SET_CURRENT;
            mcfb_pkg::CMD_SET_SPEED:   push_req.id = mcfb_pkg::ID_SET_SPEED;
            default:                   push_req.id = mcfb_pkg::ID_KEEP_ALIVE;
        endcase
    end

endmodule

[src/mcfb_queue.sv]
// Short request queue between the front end and the byte sequencer.
`timescale 1ns / 1ps

module mcfb_queue
#(
    parameter int DEPTH = mcfb_pkg::QUEUE_DEPTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  mcfb_pkg::frame_req_t push_req,
    output logic                 full,
    input  logic                 pop,
    output mcfb_pkg::queue_head_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mcfb_pkg::frame_req_t entry_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 do_push;
    logic                 do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.req   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head.valid;

    // Advance pointers with wrap at the depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed request
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_req;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not follow a push");

    a_count_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && !do_push) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("queue count did not follow a pop");
`endif

endmodule

[src/mcfb_back.sv]
// Back end: byte sequencer with running CRC and registered byte output.
`timescale 1ns / 1ps

module mcfb_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  mcfb_pkg::queue_head_t head,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            out_byte,
    output logic                  out_last
);

    // One byte of CRC-16/XMODEM, MSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int b = 0; b < 8; b++)
        begin
            c = c[15] ? ({c[14:0], 1'b0} ^ mcfb_pkg::CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    logic [3:0]  idx_reg;
    logic [3:0]  idx_next;
    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [7:0]  out_byte_reg;
    logic [7:0]  out_byte_next;
    logic        out_last_reg;
    logic        out_last_next;
    logic        load;
    logic        step;
    logic        is_last;
    logic        is_payload;
    logic [7:0]  byte_sel;
    logic [31:0] scaled;

    assign scaled = head.req.scaled;
    assign load   = !out_valid_reg || out_ready;
    assign step   = load && head.valid;

    // Pick the frame byte for the current position
    always_comb
    begin
        byte_sel = mcfb_pkg::FRAME_END;
        if (idx_reg == mcfb_pkg::POS_START)
        begin
            byte_sel = mcfb_pkg::FRAME_START;
        end
        else if (idx_reg == mcfb_pkg::POS_LEN)
        begin
            byte_sel = head.req.long_frame ? mcfb_pkg::PAY_LEN_LONG : mcfb_pkg::PAY_LEN_SHORT;
        end
        else if (idx_reg == mcfb_pkg::POS_ID)
        begin
            byte_sel = head.req.id;
        end
        else if (!head.req.long_frame)
        begin
            if (idx_reg == mcfb_pkg::POS_SHORT_CRCH)
            begin
                byte_sel = crc_reg[15:8];
            end
            else if (idx_reg == mcfb_pkg::POS_SHORT_CRCL)
            begin
                byte_sel = crc_reg[7:0];
            end
        end
        else
        begin
            if (idx_reg == mcfb_pkg::POS_VAL_B3)
            begin
                byte_sel = scaled[31:24];
            end
            else if (idx_reg == mcfb_pkg::POS_VAL_B2)
            begin
                byte_sel = scaled[23:16];
            end
            else if (idx_reg == mcfb_pkg::POS_VAL_B1)
            begin
                byte_sel = scaled[15:8];
            end
            else if (idx_reg == mcfb_pkg::POS_VAL_B0)
            begin
                byte_sel = scaled[7:0];
            end
            else if (idx_reg == mcfb_pkg::POS_LONG_CRCH)
            begin
                byte_sel = crc_reg[15:8];
            end
            else if (idx_reg == mcfb_pkg::POS_LONG_CRCL)
            begin
                byte_sel = crc_reg[7:0];
            end
        end
    end

    assign is_last = head.req.long_frame ? (idx_reg == mcfb_pkg::POS_LONG_END)
                                         : (idx_reg == mcfb_pkg::POS_SHORT_END);
    assign is_payload = (idx_reg == mcfb_pkg::POS_ID)
                     || (head.req.long_frame && (idx_reg >= mcfb_pkg::POS_VAL_B3)
                                             && (idx_reg <= mcfb_pkg::POS_VAL_B0));
    assign pop = step && is_last;

    // Advance the sequencer and fold payload bytes into the CRC
    always_comb
    begin
        idx_next       = idx_reg;
        crc_next       = crc_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        if (step)
        begin
            idx_next       = is_last ? mcfb_pkg::POS_START : idx_reg + 1'b1;
            out_valid_next = 1'b1;
            out_byte_next  = byte_sel;
            out_last_next  = is_last;
            if (is_payload)
            begin
                crc_next = crc_byte((idx_reg == mcfb_pkg::POS_ID) ? mcfb_pkg::CRC_INIT : crc_reg,
                                    byte_sel);
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= mcfb_pkg::POS_START;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold output payload and CRC
    always_ff @(posedge clk)
    begin
        crc_reg      <= crc_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

`ifndef SYNTHESIS
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= mcfb_pkg::POS_LONG_END)
        else $error("byte position beyond frame length");

    a_last_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_last_reg) |-> (out_byte_reg == mcfb_pkg::FRAME_END))
        else $error("last flag on a byte other than the end byte");

    a_start_first: assert property (@(posedge clk) disable iff (!rst_n)
        (step && (idx_reg == mcfb_pkg::POS_START)) |=> (out_byte_reg == mcfb_pkg::FRAME_START))
        else $error("frame did not open with the start byte");

    a_pop_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (idx_reg == mcfb_pkg::POS_START))
        else $error("sequencer did not restart after a frame");
`endif

endmodule
